>>> design/ewtm_pkg.sv
// Shared constants and register codes for the echo width trimmed-mean filter.
// No dependencies; every other design file refers to it by scoped names.
package ewtm_pkg;

	localparam int SAMPLE_COUNT_DEF = 20;
	localparam int TRIM_START_DEF   = 7;
	localparam int KEEP_COUNT_DEF   = 5;
	localparam int QUEUE_DEPTH_DEF  = 2;

	localparam int TIME_W     = 16;
	localparam int DIV_W      = 16;
	localparam int MULT_W     = 8;
	localparam int DIST_W     = 19;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [DIST_W-1:0] DIST_MAX    = '1;
	localparam logic [DIV_W-1:0]  DIV_RESET   = 16'd254;
	localparam logic [MULT_W-1:0] MULT_RESET  = 8'd20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_DIVISOR    = 2'd0,
		REG_SCALE_MULTIPLIER = 2'd1
	} cfg_reg_t;

endpackage

>>> design/ewtm_front.sv
// Front end: edge phase tracking, start time capture and pulse width per falling edge.
// Depends on ewtm_pkg; pushes {last, slot, width} entries into ewtm_queue.
module ewtm_front #(
	parameter int SAMPLE_COUNT = ewtm_pkg::SAMPLE_COUNT_DEF,
	parameter int IDX_W        = $clog2(SAMPLE_COUNT),
	parameter int ENTRY_W      = 1 + IDX_W + ewtm_pkg::TIME_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [ewtm_pkg::TIME_W-1:0] capture_time,
	output logic                        in_stall,
	input  logic                        q_full,
	output logic                        push,
	output logic [ENTRY_W-1:0]          entry
);

	logic                        phase_q;
	logic [ewtm_pkg::TIME_W-1:0] start_q;
	logic [IDX_W-1:0]            cnt_q;
	logic                        accept;
	logic                        last;
	logic [ewtm_pkg::TIME_W-1:0] width;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && phase_q;
	assign last     = (cnt_q == IDX_W'(SAMPLE_COUNT - 1));
	// modulo 2^16 difference handles a wrapped timer
	assign width    = capture_time - start_q;
	assign entry    = {last, cnt_q, width};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			start_q <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			phase_q <= !phase_q;
			if (!phase_q) begin
				start_q <= capture_time;
			end else if (last) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

>>> design/ewtm_queue.sv
// Small FIFO between the front end and the rank/sum sequencer.
// Depends on ewtm_pkg for the default depth.
module ewtm_queue #(
	parameter int DEPTH = ewtm_pkg::QUEUE_DEPTH_DEF,
	parameter int W     = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         pop_valid,
	output logic [W-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> design/ewtm_rank_sum.sv
// Back end: width buffer memory and the rank-count sequencer that sums the trim window.
// Depends on ewtm_pkg; fed by ewtm_queue, hands the sum to ewtm_scale.
module ewtm_rank_sum #(
	parameter int SAMPLE_COUNT = ewtm_pkg::SAMPLE_COUNT_DEF,
	parameter int TRIM_START   = ewtm_pkg::TRIM_START_DEF,
	parameter int KEEP_COUNT   = ewtm_pkg::KEEP_COUNT_DEF,
	parameter int IDX_W        = $clog2(SAMPLE_COUNT),
	parameter int ENTRY_W      = 1 + IDX_W + ewtm_pkg::TIME_W,
	parameter int SUM_W        = ewtm_pkg::TIME_W + $clog2(KEEP_COUNT + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  logic [ENTRY_W-1:0] q_data,
	output logic               q_pop,
	output logic               sum_valid,
	output logic [SUM_W-1:0]   sum,
	input  logic               sum_ready
);

	localparam int TW    = ewtm_pkg::TIME_W;
	localparam int WIN_W = 8;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_GET  = 6'b000010,
		S_HOLD = 6'b000100,
		S_SCAN = 6'b001000,
		S_ACC  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t           state_q;
	logic [TW-1:0]    mem_q [SAMPLE_COUNT];
	logic [TW-1:0]    rdata_q;
	logic [IDX_W-1:0] rd_addr;
	logic [TW-1:0]    vi_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] c_q;
	logic [IDX_W:0]   rank_q;
	logic [SUM_W-1:0] sum_q;
	logic             below;
	logic             in_win;
	logic [WIN_W-1:0] rank_ext;
	logic             q_last;
	logic [IDX_W-1:0] q_slot;
	logic [TW-1:0]    q_width;

	assign {q_last, q_slot, q_width} = q_data;
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign sum_valid = (state_q == S_OUT);
	assign sum       = sum_q;

	// ties broken by index, which gives the position a stable sort would
	assign below    = (rdata_q < vi_q) || ((rdata_q == vi_q) && (c_q < i_q));
	assign rank_ext = WIN_W'(rank_q);
	assign in_win   = (rank_ext >= WIN_W'(TRIM_START)) &&
	                  (rank_ext < WIN_W'(TRIM_START + KEEP_COUNT));

	always_comb begin
		case (state_q)
			S_HOLD:  rd_addr = '0;
			S_SCAN:  rd_addr = j_q;
			default: rd_addr = i_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			mem_q[q_slot] <= q_width;
		end
		rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			c_q     <= '0;
			rank_q  <= '0;
			sum_q   <= '0;
			vi_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_pop && q_last) begin
						i_q     <= '0;
						sum_q   <= '0;
						state_q <= S_GET;
					end
				end
				S_GET: begin
					state_q <= S_HOLD;
				end
				S_HOLD: begin
					vi_q    <= rdata_q;
					j_q     <= IDX_W'(1);
					c_q     <= '0;
					rank_q  <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (below) begin
						rank_q <= rank_q + 1'b1;
					end
					if (j_q != IDX_W'(SAMPLE_COUNT - 1)) begin
						j_q <= j_q + 1'b1;
					end
					if (c_q == IDX_W'(SAMPLE_COUNT - 1)) begin
						state_q <= S_ACC;
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				S_ACC: begin
					if (in_win) begin
						sum_q <= sum_q + SUM_W'(vi_q);
					end
					if (i_q == IDX_W'(SAMPLE_COUNT - 1)) begin
						state_q <= S_OUT;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_GET;
					end
				end
				S_OUT: begin
					if (sum_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> design/ewtm_scale.sv
// Scaling unit: bit-serial restoring divide, one multiply, saturation, output register.
// Depends on ewtm_pkg; takes the trimmed sum from ewtm_rank_sum.
module ewtm_scale #(
	parameter int SUM_W = 19
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sum_valid,
	input  logic [SUM_W-1:0]            sum,
	output logic                        sum_ready,
	input  logic [ewtm_pkg::DIV_W-1:0]  divisor,
	input  logic [ewtm_pkg::MULT_W-1:0] multiplier,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ewtm_pkg::DIST_W-1:0] distance
);

	localparam int DW     = ewtm_pkg::DIV_W;
	localparam int PROD_W = SUM_W + ewtm_pkg::MULT_W;
	localparam int CNT_W  = $clog2(SUM_W);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DIV  = 5'b00010,
		S_MUL  = 5'b00100,
		S_SAT  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t                        state_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [SUM_W-1:0]              quo_q;
	logic [DW-1:0]                 rem_q;
	logic [DW-1:0]                 div_q;
	logic [PROD_W-1:0]             prod_q;
	logic [ewtm_pkg::DIST_W-1:0]   dist_q;
	logic [DW:0]                   trial;
	logic                          fits;

	assign sum_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign distance  = dist_q;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				quo_q <= sum;
				rem_q <= '0;
				// a zero divisor acts as one
				div_q <= (divisor == '0) ? DW'(1) : divisor;
			end
			S_DIV: begin
				rem_q <= fits ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
				quo_q <= {quo_q[SUM_W-2:0], fits};
			end
			S_MUL: begin
				prod_q <= PROD_W'(quo_q) * PROD_W'(multiplier);
			end
			S_SAT: begin
				dist_q <= (prod_q > PROD_W'(ewtm_pkg::DIST_MAX)) ?
				          ewtm_pkg::DIST_MAX : prod_q[ewtm_pkg::DIST_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (sum_valid) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(SUM_W - 1)) begin
						state_q <= S_MUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_MUL: state_q <= S_SAT;
				S_SAT: state_q <= S_OUT;
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> design/echo_width_trimmed_mean_top.sv
// Top level of the echo width trimmed-mean filter: config registers and block wiring.
// Depends on ewtm_pkg, ewtm_front, ewtm_queue, ewtm_rank_sum and ewtm_scale.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  input    | in_valid / in_stall  | capture_time[15:0]
//  output   | out_valid / out_stall| distance[18:0]
//  config   | cfg_valid / cfg_ready| cfg_index[1:0], cfg_data[15:0]
//
// Each edge transaction is taken while the two-entry queue has room.
// A batch close drains the queued widths, then rank-counts them over the width memory,
// then runs the bit-serial divide, multiply and saturate before distance is shown.
// Reset is asynchronous, active low; no clearing pass is needed.
// out_stall holds the result in its register; in_stall rises only when the queue fills.
module echo_width_trimmed_mean_top #(
	parameter int SAMPLE_COUNT = ewtm_pkg::SAMPLE_COUNT_DEF,
	parameter int TRIM_START   = ewtm_pkg::TRIM_START_DEF,
	parameter int KEEP_COUNT   = ewtm_pkg::KEEP_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [ewtm_pkg::TIME_W-1:0]     capture_time,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ewtm_pkg::DIST_W-1:0]     distance,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ewtm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ewtm_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W   = $clog2(SAMPLE_COUNT);
	localparam int ENTRY_W = 1 + IDX_W + ewtm_pkg::TIME_W;
	localparam int SUM_W   = ewtm_pkg::TIME_W + $clog2(KEEP_COUNT + 1);

	logic [ewtm_pkg::DIV_W-1:0]  divisor_q;
	logic [ewtm_pkg::MULT_W-1:0] multiplier_q;
	logic                        push;
	logic [ENTRY_W-1:0]          push_entry;
	logic                        q_full;
	logic                        q_pop;
	logic                        q_valid;
	logic [ENTRY_W-1:0]          q_data;
	logic                        sum_valid;
	logic                        sum_ready;
	logic [SUM_W-1:0]            sum;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q    <= ewtm_pkg::DIV_RESET;
			multiplier_q <= ewtm_pkg::MULT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ewtm_pkg::REG_SCALE_DIVISOR:    divisor_q    <= cfg_data;
				ewtm_pkg::REG_SCALE_MULTIPLIER: multiplier_q <= cfg_data[ewtm_pkg::MULT_W-1:0];
				default: ;
			endcase
		end
	end

	ewtm_front #(
		.SAMPLE_COUNT(SAMPLE_COUNT),
		.IDX_W       (IDX_W),
		.ENTRY_W     (ENTRY_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.capture_time(capture_time),
		.in_stall    (in_stall),
		.q_full      (q_full),
		.push        (push),
		.entry       (push_entry)
	);

	ewtm_queue #(
		.DEPTH(ewtm_pkg::QUEUE_DEPTH_DEF),
		.W    (ENTRY_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_entry),
		.full     (q_full),
		.pop      (q_pop),
		.pop_valid(q_valid),
		.pop_data (q_data)
	);

	ewtm_rank_sum #(
		.SAMPLE_COUNT(SAMPLE_COUNT),
		.TRIM_START  (TRIM_START),
		.KEEP_COUNT  (KEEP_COUNT),
		.IDX_W       (IDX_W),
		.ENTRY_W     (ENTRY_W),
		.SUM_W       (SUM_W)
	) u_rank_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_pop    (q_pop),
		.sum_valid(sum_valid),
		.sum      (sum),
		.sum_ready(sum_ready)
	);

	ewtm_scale #(
		.SUM_W(SUM_W)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.sum_valid (sum_valid),
		.sum       (sum),
		.sum_ready (sum_ready),
		.divisor   (divisor_q),
		.multiplier(multiplier_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.distance  (distance)
	);

	// a falling-edge transaction must never land on a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full))
		else $error("width queue overflow");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty width queue");

	// sum handoff is a single transaction
	a_sum_once: assert property (@(posedge clk) disable iff (!arst_n)
		(sum_valid && sum_ready) |=> !sum_valid)
		else $error("trimmed sum offered twice");

	// scaling unit is busy while a result waits
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !sum_ready)
		else $error("scaler accepts a sum while a result is pending");

endmodule
